// ===== hw/rtl/scfa_pkg.sv =====
// Shared constants and types for the second-chance page frame allocator.
package scfa_pkg;

   localparam int FRAME_COUNT   = 16;
   localparam int IDX_W         = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
   localparam int CNT_W         = IDX_W + 1;

   localparam int OWNER_W       = 8;
   localparam int PAGE_W        = 16;
   localparam int STAMP_W       = 32;
   localparam int REC_W         = OWNER_W + PAGE_W + STAMP_W;
   localparam int REQ_DATA_W    = 56;
   localparam int FRAME_INDEX_W = 4;
   localparam int RSP_DATA_W    = 8;

   localparam logic FUNC_ALLOC   = 1'b0;
   localparam logic FUNC_RELEASE = 1'b1;

   // one entry presented to the compare unit
   typedef struct packed {
      logic             vld;
      logic [IDX_W-1:0] idx;
      logic             valid;
      logic             chance;
   } scan_step_type;

   // running outcome of a table pass
   typedef struct packed {
      logic             free_found;
      logic [IDX_W-1:0] free_idx;
      logic             old_found;
      logic [IDX_W-1:0] old_idx;
   } scan_result_type;

endpackage

// ===== hw/rtl/scfa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module scfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                          wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/scfa_scan.sv =====
// Shared compare unit: one frame per cycle, tracks first free and oldest candidate.
module scfa_scan import scfa_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 clear,
   input  scan_step_type        step,
   input  logic [STAMP_W-1:0]   rd_stamp,
   input  logic [OWNER_W-1:0]   rd_owner,
   input  logic [OWNER_W-1:0]   owner_ref,
   output scan_result_type      result,
   output logic                 owner_hit
);

   logic               free_found_ff, free_found_in;
   logic [IDX_W-1:0]   free_idx_ff, free_idx_in;
   logic               old_found_ff, old_found_in;
   logic [IDX_W-1:0]   old_idx_ff, old_idx_in;
   logic [STAMP_W-1:0] old_stamp_ff, old_stamp_in;
   logic               older;

   // strict less-than keeps the lowest index on equal stamps
   assign older = !old_found_ff || (rd_stamp < old_stamp_ff);

   always_comb begin
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      old_found_in  = old_found_ff;
      old_idx_in    = old_idx_ff;
      old_stamp_in  = old_stamp_ff;
      if (clear) begin
         free_found_in = 1'b0;
         old_found_in  = 1'b0;
      end else if (step.vld) begin
         if (!step.valid && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = step.idx;
         end
         if (step.valid && !step.chance && older) begin
            old_found_in = 1'b1;
            old_idx_in   = step.idx;
            old_stamp_in = rd_stamp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_found_ff <= 1'b0;
         old_found_ff  <= 1'b0;
      end else begin
         free_found_ff <= free_found_in;
         old_found_ff  <= old_found_in;
      end
      free_idx_ff  <= free_idx_in;
      old_idx_ff   <= old_idx_in;
      old_stamp_ff <= old_stamp_in;
   end

   assign owner_hit = step.vld && step.valid && (rd_owner == owner_ref);

   assign result.free_found = free_found_ff;
   assign result.free_idx   = free_idx_ff;
   assign result.old_found  = old_found_ff;
   assign result.old_idx    = old_idx_ff;

endmodule

// ===== hw/rtl/page_frame_second_chance_allocator.sv =====
// Top level: sequencer, frame flags and record RAM of the page frame allocator.
//
//  channel | direction | tdata                                   | tuser
//  req     | in        | owner_id, page_num, timestamp           | func
//  rsp     | out       | frame_index, evicted, done_res, pad     | -
//
// Allocate with a free frame: a scan pass, then the record write and the response.
// Allocate on a full table: a scan pass, or a sweep and a second pass when every chance
// bit was set. Release: a scan pass that clears the frames of the owner.
// The record RAM read port is read one frame per cycle per pass.
// Reset frees all frames; the RAM contents are only used for valid frames.
// req_tready is low while a transaction is in work; a stalled earlier rsp holds the block in
// its final state until taken.
module page_frame_second_chance_allocator import scfa_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // owner_id[7:0], page_num[23:8], timestamp[55:24]
   input  logic                  req_tuser,  // func
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata   // frame_index[3:0], evicted[4], done_res[5], zero[7:6]
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_DECIDE = 3'd2;
   localparam logic [2:0] S_SWEEP  = 3'd3;
   localparam logic [2:0] S_WRITE  = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   logic [2:0]             state_ff, state_in;
   logic                   func_ff, func_in;
   logic [OWNER_W-1:0]     owner_ff, owner_in;
   logic [PAGE_W-1:0]      page_ff, page_in;
   logic [STAMP_W-1:0]     stamp_ff, stamp_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   pend_vld_ff, pend_vld_in;
   logic [IDX_W-1:0]       pend_idx_ff, pend_idx_in;
   logic [IDX_W-1:0]       slot_ff, slot_in;
   logic                   evict_ff, evict_in;
   logic [FRAME_COUNT-1:0] valid_ff, valid_in;
   logic [FRAME_COUNT-1:0] chance_ff, chance_in;
   logic                   rsp_vld_ff, rsp_vld_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;

   logic                   req_acc;
   logic                   scan_more;
   logic                   ram_we;
   logic [REC_W-1:0]       ram_wdata;
   logic [REC_W-1:0]       ram_rdata;
   scan_step_type          step;
   scan_result_type        result;
   logic                   owner_hit;
   logic                   scan_clear;

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign scan_more  = (cnt_ff < CNT_W'(FRAME_COUNT));
   assign scan_clear = (state_ff == S_IDLE) || (state_ff == S_SWEEP);

   assign step.vld    = (state_ff == S_SCAN) && pend_vld_ff;
   assign step.idx    = pend_idx_ff;
   assign step.valid  = valid_ff[pend_idx_ff];
   assign step.chance = chance_ff[pend_idx_ff];

   assign ram_we    = (state_ff == S_WRITE);
   assign ram_wdata = {stamp_ff, page_ff, owner_ff};

   scfa_ram #(
      .WIDTH(REC_W),
      .DEPTH(FRAME_COUNT)
   ) u_rec_ram (
      .clock(clock),
      .we   (ram_we),
      .waddr(slot_ff),
      .wdata(ram_wdata),
      .raddr(cnt_ff[IDX_W-1:0]),
      .rdata(ram_rdata)
   );

   scfa_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .clear    (scan_clear),
      .step     (step),
      .rd_stamp (ram_rdata[REC_W-1 -: STAMP_W]),
      .rd_owner (ram_rdata[OWNER_W-1:0]),
      .owner_ref(owner_ff),
      .result   (result),
      .owner_hit(owner_hit)
   );

   always_comb begin
      state_in    = state_ff;
      func_in     = func_ff;
      owner_in    = owner_ff;
      page_in     = page_ff;
      stamp_in    = stamp_ff;
      cnt_in      = cnt_ff;
      pend_vld_in = pend_vld_ff;
      pend_idx_in = pend_idx_ff;
      slot_in     = slot_ff;
      evict_in    = evict_ff;
      valid_in    = valid_ff;
      chance_in   = chance_ff;
      rsp_vld_in  = rsp_vld_ff;
      rsp_data_in = rsp_data_ff;

      if (rsp_vld_ff && rsp_tready) begin
         rsp_vld_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               func_in     = req_tuser;
               owner_in    = req_tdata[OWNER_W-1:0];
               page_in     = req_tdata[OWNER_W +: PAGE_W];
               stamp_in    = req_tdata[OWNER_W+PAGE_W +: STAMP_W];
               cnt_in      = '0;
               pend_vld_in = 1'b0;
               state_in    = S_SCAN;
            end
         end
         S_SCAN: begin
            // read issued at cnt, compared in the next cycle
            pend_vld_in = scan_more;
            pend_idx_in = cnt_ff[IDX_W-1:0];
            if (scan_more) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end else begin
               state_in = S_DECIDE;
            end
            if (func_ff == FUNC_RELEASE && owner_hit) begin
               valid_in[pend_idx_ff] = 1'b0;
            end
         end
         S_DECIDE: begin
            if (func_ff == FUNC_RELEASE) begin
               slot_in  = '0;
               evict_in = 1'b0;
               state_in = S_DONE;
            end else if (result.free_found) begin
               slot_in  = result.free_idx;
               evict_in = 1'b0;
               state_in = S_WRITE;
            end else if (result.old_found) begin
               slot_in  = result.old_idx;
               evict_in = 1'b1;
               state_in = S_WRITE;
            end else begin
               state_in = S_SWEEP;
            end
         end
         S_SWEEP: begin
            chance_in   = chance_ff & ~valid_ff;
            cnt_in      = '0;
            pend_vld_in = 1'b0;
            state_in    = S_SCAN;
         end
         S_WRITE: begin
            valid_in[slot_ff]  = 1'b1;
            chance_in[slot_ff] = 1'b1;
            state_in           = S_DONE;
         end
         S_DONE: begin
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in  = 1'b1;
               rsp_data_in = {(RSP_DATA_W-FRAME_INDEX_W-2)'(0), 1'b1, evict_ff,
                              FRAME_INDEX_W'(slot_ff)};
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         cnt_ff      <= '0;
         pend_vld_ff <= 1'b0;
         valid_ff    <= '0;
         chance_ff   <= '0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         pend_vld_ff <= pend_vld_in;
         valid_ff    <= valid_in;
         chance_ff   <= chance_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
      func_ff     <= func_in;
      owner_ff    <= owner_in;
      page_ff     <= page_in;
      stamp_ff    <= stamp_in;
      pend_idx_ff <= pend_idx_in;
      slot_ff     <= slot_in;
      evict_ff    <= evict_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== hw/rtl/scfa_checker.sv =====
// Port-level checker for the page frame allocator, bound to the top level.
module scfa_checker import scfa_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp transaction changed while stalled");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req accepted again before work finished");

   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("rsp raised without a transaction in work");

   a_rsp_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[FRAME_INDEX_W+1] &&
                     (rsp_tdata[RSP_DATA_W-1:FRAME_INDEX_W+2] == '0))
      else $error("rsp done flag or padding wrong");

   a_rsp_known: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !$isunknown(rsp_tdata))
      else $error("rsp data unknown while valid");

endmodule

bind page_frame_second_chance_allocator scfa_checker u_scfa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);
